### design/lru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg: shared types and constants for the LRU page replacement block
// Word layouts of the reference and result channels, config width, defaults.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int PAGE_BITS   = 16;
  localparam int FRAMES_DEF  = 8;
  localparam int CFG_BITS    = 4;
  localparam int IDX_OUT_W   = 3;
  localparam int FAULT_BITS  = 32;

  localparam logic [CFG_BITS-1:0] FRAMES_IN_USE_RST = CFG_BITS'(8);

  typedef logic [CFG_BITS-1:0] cfg_word_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_number;
    logic                 last_reference;
  } in_word_t;

  typedef struct packed {
    logic                  hit;
    logic [IDX_OUT_W-1:0]  frame_index;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [FAULT_BITS-1:0] fault_count;
  } out_word_t;

  // status from the compare unit back to the sequencer
  typedef struct packed {
    logic found;
    logic empty_found;
  } scan_flags_t;

endpackage

### design/lru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/lru_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_scan: shared compare unit for the frame scan
// Takes one frame per step; tracks first match, first empty frame and the
// oldest frame (largest rank, lowest index on a tie).
// ----------------------------------------------------------------------------
module lru_scan #(
  parameter int FRAMES = lru_pkg::FRAMES_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic                                         step_en,
  input  logic [lru_pkg::PAGE_BITS-1:0]                key,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] step_idx,
  input  logic [lru_pkg::PAGE_BITS-1:0]                step_page,
  input  logic                                         step_valid,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] step_rank,
  output lru_pkg::scan_flags_t                         flags,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] found_idx,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] empty_idx,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] vic_idx,
  output logic [lru_pkg::PAGE_BITS-1:0]                vic_page
);
  import lru_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  scan_flags_t          flags_r, flags_nxt;
  logic                 vic_have_r, vic_have_nxt;
  logic [IW-1:0]        found_idx_r, found_idx_nxt;
  logic [IW-1:0]        empty_idx_r, empty_idx_nxt;
  logic [IW-1:0]        vic_idx_r, vic_idx_nxt;
  logic [IW-1:0]        vic_rank_r, vic_rank_nxt;
  logic [PAGE_BITS-1:0] vic_page_r, vic_page_nxt;

  always_comb begin
    flags_nxt     = flags_r;
    vic_have_nxt  = vic_have_r;
    found_idx_nxt = found_idx_r;
    empty_idx_nxt = empty_idx_r;
    vic_idx_nxt   = vic_idx_r;
    vic_rank_nxt  = vic_rank_r;
    vic_page_nxt  = vic_page_r;
    if (start) begin
      flags_nxt    = '0;
      vic_have_nxt = 1'b0;
    end else if (step_en) begin
      if (step_valid && (step_page == key) && !flags_r.found) begin
        flags_nxt.found = 1'b1;
        found_idx_nxt   = step_idx;
      end
      if (!step_valid && !flags_r.empty_found) begin
        flags_nxt.empty_found = 1'b1;
        empty_idx_nxt         = step_idx;
      end
      // strict compare keeps the lowest index on a tie
      if (!vic_have_r || (step_rank > vic_rank_r)) begin
        vic_have_nxt = 1'b1;
        vic_idx_nxt  = step_idx;
        vic_rank_nxt = step_rank;
        vic_page_nxt = step_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r    <= '0;
      vic_have_r <= 1'b0;
    end else begin
      flags_r    <= flags_nxt;
      vic_have_r <= vic_have_nxt;
    end
    found_idx_r <= found_idx_nxt;
    empty_idx_r <= empty_idx_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_rank_r  <= vic_rank_nxt;
    vic_page_r  <= vic_page_nxt;
  end

  assign flags     = flags_r;
  assign found_idx = found_idx_r;
  assign empty_idx = empty_idx_r;
  assign vic_idx   = vic_idx_r;
  assign vic_page  = vic_page_r;

endmodule

### design/lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement: LRU page frame table with fault counting
// Each reference word is looked up in the frame table; hit, fill or evict.
// ----------------------------------------------------------------------------
// Usage:
//   Reference channel (in_valid / in_stall / in_word): one page number per
//   word plus a last-reference flag. Result channel (out_valid / out_stall /
//   out_word): one result word per reference. Config: cfg_we / cfg_wdata
//   writes frames_in_use (clamped to 1..FRAMES); write only while idle.
// Timing:
//   After the accepting edge the block issues frame reads to the page RAM,
//   one per active frame (n, the clamped frame count), lets the last read
//   pass the compare unit in the drain state, then writes the result in
//   the update state. The single compare unit seeing one frame per cycle
//   sets this pace. The block returns to idle before it takes a new word.
//   in_stall is high from accept until the update cycle has written the
//   result register. A result waiting on out_stall does not block the next
//   accept, but the following update waits until the result is taken.
// Reset:
//   Synchronous, active low. Clears valid marks, restores index-order
//   recency, zeroes the fault count, sets frames_in_use to 8. The page RAM
//   is not cleared; valid marks gate every read of it.
//   A word flagged last_reference clears the table after its result.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAMES = lru_pkg::FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lru_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output lru_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  lru_pkg::cfg_word_t cfg_wdata
);
  import lru_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  state_t                state_r, state_nxt;
  cfg_word_t             cfg_r, cfg_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         nm1_r, nm1_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic                  last_r, last_nxt;
  logic                  step_en_r, step_en_nxt;
  logic [IW-1:0]         step_idx_r, step_idx_nxt;
  logic [FRAMES-1:0]     valid_r, valid_nxt;
  logic [IW-1:0]         rank_r [FRAMES];
  logic [IW-1:0]         rank_nxt [FRAMES];
  logic [FAULT_BITS-1:0] fault_r, fault_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;

  // compare unit results
  scan_flags_t           flags;
  logic [IW-1:0]         found_idx, empty_idx, vic_idx;
  logic [PAGE_BITS-1:0]  vic_page;
  logic [PAGE_BITS-1:0]  step_page;

  logic                  accept;
  logic                  upd_go;
  logic                  miss;
  logic                  ev_valid;
  logic [IW-1:0]         target;
  logic [IW-1:0]         tgt_rank;
  logic                  ram_we;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  // update waits only if a previous result is still held by the receiver
  assign upd_go   = (state_r == ST_UPDATE) && !(out_valid_r && out_stall);
  assign miss     = !flags.found;
  assign ev_valid = miss && !flags.empty_found;
  assign target   = flags.found ? found_idx : (flags.empty_found ? empty_idx : vic_idx);
  assign tgt_rank = rank_r[target];
  assign ram_we   = upd_go && miss;

  lru_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (target),
    .wdata (page_r),
    .raddr (idx_r),
    .rdata (step_page)
  );

  lru_scan #(
    .FRAMES (FRAMES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .step_en    (step_en_r),
    .key        (page_r),
    .step_idx   (step_idx_r),
    .step_page  (step_page),
    .step_valid (valid_r[step_idx_r]),
    .step_rank  (rank_r[step_idx_r]),
    .flags      (flags),
    .found_idx  (found_idx),
    .empty_idx  (empty_idx),
    .vic_idx    (vic_idx),
    .vic_page   (vic_page)
  );

  always_comb begin
    int unsigned n;
    state_nxt     = state_r;
    cfg_nxt       = cfg_r;
    idx_nxt       = idx_r;
    nm1_nxt       = nm1_r;
    page_nxt      = page_r;
    last_nxt      = last_r;
    step_en_nxt   = 1'b0;
    step_idx_nxt  = step_idx_r;
    valid_nxt     = valid_r;
    rank_nxt      = rank_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (cfg_we) begin
      cfg_nxt = cfg_wdata;
    end

    // clamp active frame count to 1..FRAMES
    n = 32'(cfg_r);
    if (n == 0) begin
      n = 1;
    end else if (n > FRAMES) begin
      n = FRAMES;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          page_nxt  = in_word.page_number;
          last_nxt  = in_word.last_reference;
          nm1_nxt   = IW'(n - 1);
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        step_en_nxt  = 1'b1;
        step_idx_nxt = idx_r;
        if (idx_r == nm1_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) begin
          if (miss) begin
            valid_nxt[target] = 1'b1;
            if (fault_r != '1) begin
              fault_nxt = fault_r + FAULT_BITS'(1);
            end
          end
          for (int g = 0; g < FRAMES; g++) begin
            if (rank_r[g] < tgt_rank) begin
              rank_nxt[g] = rank_r[g] + IW'(1);
            end
          end
          rank_nxt[target] = '0;

          out_word_nxt.hit           = flags.found;
          out_word_nxt.frame_index   = IDX_OUT_W'(target);
          out_word_nxt.evicted_valid = ev_valid;
          out_word_nxt.evicted_page  = ev_valid ? vic_page : '0;
          out_word_nxt.fault_count   = fault_nxt;
          out_valid_nxt              = 1'b1;

          // end of run: table and count back to reset values
          if (last_r) begin
            valid_nxt = '0;
            fault_nxt = '0;
            for (int g = 0; g < FRAMES; g++) begin
              rank_nxt[g] = IW'(g);
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= FRAMES_IN_USE_RST;
      step_en_r   <= 1'b0;
      valid_r     <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < FRAMES; g++) begin
        rank_r[g] <= IW'(g);
      end
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      step_en_r   <= step_en_nxt;
      valid_r     <= valid_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      rank_r      <= rank_nxt;
    end
    idx_r      <= idx_nxt;
    nm1_r      <= nm1_nxt;
    page_r     <= page_nxt;
    last_r     <= last_nxt;
    step_idx_r <= step_idx_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  // an accepted word always starts a frame scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SCAN))
    else $error("accepted word did not start a scan");

  // scan index never passes the active frame count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= nm1_r))
    else $error("scan index beyond active frames");

  // a hit always lands on a valid frame
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && flags.found) |-> valid_r[found_idx])
    else $error("hit on an invalid frame");

  // a result is never both a hit and an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.hit && out_word_r.evicted_valid))
    else $error("hit result carries an eviction");

  // a fault that does not end the run leaves a nonzero count
  a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && miss && !last_r) |=> (fault_r != '0))
    else $error("fault count zero after a fault");
`endif

endmodule

### test/lru_page_replacement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_tb: self-checking bench for the LRU page frame table
// Streams page references through the block and scores every result word
// against an in-bench table model: hits, fills, LRU evictions, fault counts,
// end-of-run clears and frame-count changes, under several idle and stall
// mixes plus one long hold-off on the result channel.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
  import lru_pkg::*;

  localparam int NFR         = FRAMES_DEF;
  localparam int QUIET_LIMIT = 4000;     // cycles with no word moving on either side
  localparam int TAIL_CYCLES = NFR + 8;  // beyond one reference's latency

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  cfg_word_t cfg_wdata = '0;

  lru_page_replacement #(
    .FRAMES(NFR)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Frame table model
  // --------------------------------------------------------------------------
  logic [PAGE_BITS-1:0]  tbl_page  [NFR];
  logic                  tbl_valid [NFR];
  logic [IDX_OUT_W-1:0]  tbl_age   [NFR];  // 0 = most recently used
  logic [FAULT_BITS-1:0] tbl_faults;
  cfg_word_t             tbl_frames;

  out_word_t expected_results[$];

  int n_bad;        // mismatches, strays and leftovers
  int n_refs;       // references accepted
  int n_results;    // result words taken
  int n_cfg;        // frame-count writes
  int snd_pct;      // sender idle chance per cycle, percent
  int rcv_pct;      // receiver stall chance per cycle, percent
  int hold_req;     // long hold-off request for the receiver
  int hold_left;
  int quiet_cycles;

  function automatic void clear_tables();
    for (int f = 0; f < NFR; f++) begin
      tbl_page[f]  = '0;
      tbl_valid[f] = 1'b0;
      tbl_age[f]   = IDX_OUT_W'(f);
    end
    tbl_faults = '0;
  endfunction

  // Runs one reference through the model table and returns its result word.
  function automatic out_word_t lru_predict(in_word_t w);
    out_word_t            r;
    int                   n;
    int                   match_f;
    int                   tgt;
    logic [IDX_OUT_W-1:0] age_t;
    r = '0;
    // zero acts as one frame, anything past the table is the whole table
    n = (tbl_frames == 0) ? 1 : (int'(tbl_frames) > NFR) ? NFR : int'(tbl_frames);
    match_f = -1;
    tgt = -1;
    // lowest-index match wins when a page is resident twice
    for (int f = 0; f < n; f++) begin
      if (match_f < 0 && tbl_valid[f] && tbl_page[f] == w.page_number) match_f = f;
    end
    if (match_f >= 0) begin
      r.hit = 1'b1;
      tgt = match_f;
    end else begin
      for (int f = 0; f < n; f++) begin
        if (tgt < 0 && !tbl_valid[f]) tgt = f;
      end
      if (tgt < 0) begin
        // oldest active frame; a tie would go to the lower index
        tgt = 0;
        for (int f = 1; f < n; f++) begin
          if (tbl_age[f] > tbl_age[tgt]) tgt = f;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = tbl_page[tgt];
      end
      tbl_page[tgt]  = w.page_number;
      tbl_valid[tgt] = 1'b1;
      if (tbl_faults != '1) tbl_faults = tbl_faults + 1'b1;
    end
    // every frame younger than the target ages by one, all frames included
    age_t = tbl_age[tgt];
    for (int f = 0; f < NFR; f++) begin
      if (tbl_age[f] < age_t) tbl_age[f] = tbl_age[f] + 1'b1;
    end
    tbl_age[tgt] = '0;
    r.frame_index = IDX_OUT_W'(tgt);
    r.fault_count = tbl_faults;
    if (w.last_reference) clear_tables();
    return r;
  endfunction

  function automatic string fmt_word(out_word_t w);
    return $sformatf("hit=%0b frame=%0d evicted=%0b page=%04h faults=%0d",
                     w.hit, w.frame_index, w.evicted_valid, w.evicted_page,
                     w.fault_count);
  endfunction

  // Scores one result word against the oldest expectation.
  function automatic void check_result(out_word_t got);
    out_word_t want;
    n_results++;
    if (expected_results.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("stray result word %0d: %s", n_results, fmt_word(got));
    end else begin
      want = expected_results.pop_front();
      if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
          got.evicted_valid !== want.evicted_valid ||
          got.evicted_page !== want.evicted_page ||
          got.fault_count !== want.fault_count) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("result word %0d mismatch", n_results);
          $display("  expected %s", fmt_word(want));
          $display("  actual   %s", fmt_word(got));
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: takes words, stalls at random or for a requested hold-off.
  // Inputs are sampled pre-edge, out_stall is updated by nonblocking assign.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result(out_word);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_pct);
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved in %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Reference side
  // --------------------------------------------------------------------------
  function automatic in_word_t ref_word(logic [PAGE_BITS-1:0] page, logic last);
    in_word_t w;
    w.page_number    = page;
    w.last_reference = last;
    return w;
  endfunction

  // Offers one word, holding it until accepted. Valid stays high on return so
  // a back-to-back word needs no extra edge; callers drop it when pausing.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_results = {expected_results, lru_predict(w)};
    n_refs++;
  endtask

  // Stops offering and waits until every expected result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Frame-count write; only called with the block idle.
  task automatic write_frames(cfg_word_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_frames = v;
    n_cfg++;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases: fill, hit, eviction, narrowed range, duplicates, clamping,
  // last-reference clears, all-zero and all-one page numbers.
  task automatic test_directed_cases();
    logic [PAGE_BITS-1:0] pg [8];
    pg = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'h1234, 16'h4321};
    snd_pct = 0;
    rcv_pct = 0;
    // reset frame count: every frame fills in order
    foreach (pg[i]) send_word(ref_word(pg[i], 1'b0));
    send_word(ref_word(16'hFFFF, 1'b0));
    send_word(ref_word(16'h0000, 1'b0));
    send_word(ref_word(16'h7777, 1'b0));  // full table, LRU goes
    send_word(ref_word(16'h0001, 1'b0));
    drain_results();
    // page sits in frame 6, now outside the range: faults into a low frame
    write_frames(cfg_word_t'(2));
    send_word(ref_word(16'h1234, 1'b0));
    drain_results();
    // page now resident twice, lower frame must hit
    write_frames(cfg_word_t'(8));
    send_word(ref_word(16'h1234, 1'b0));
    drain_results();
    // zero frames behaves as one
    write_frames(cfg_word_t'(0));
    send_word(ref_word(16'h00FF, 1'b0));
    send_word(ref_word(16'h00FF, 1'b0));
    send_word(ref_word(16'hFF00, 1'b0));
    drain_results();
    write_frames(cfg_word_t'(1));
    send_word(ref_word(16'hFF00, 1'b0));
    send_word(ref_word(16'h0F0F, 1'b0));
    drain_results();
    // past the table clamps to all frames; last reference on a hit, then fault
    write_frames(cfg_word_t'(15));
    send_word(ref_word(16'h0F0F, 1'b1));
    send_word(ref_word(16'h0F0F, 1'b0));
    send_word(ref_word(16'h3C3C, 1'b1));
    drain_results();
  endtask

  // Random reference streams from small working sets, so hits and evictions
  // mix, with some noise pages and occasional end-of-run marks. The frame
  // count changes between chunks without clearing, leaving stale frames.
  task automatic test_reference_stream(int s_pct, int r_pct, int count);
    logic [PAGE_BITS-1:0] pool [16];
    int                   sent;
    int                   ws;
    int                   chunk;
    cfg_word_t            fc;
    in_word_t             w;
    snd_pct = s_pct;
    rcv_pct = r_pct;
    sent = 0;
    while (sent < count) begin
      drain_results();
      if ($urandom_range(99) < 15) begin
        fc = $urandom_range(1) ? cfg_word_t'(0) : cfg_word_t'($urandom_range(15, 9));
      end else begin
        fc = cfg_word_t'($urandom_range(NFR, 1));
      end
      write_frames(fc);
      foreach (pool[i]) pool[i] = PAGE_BITS'($urandom());
      ws    = $urandom_range(16, 1);
      chunk = $urandom_range(140, 60);
      if (chunk > count - sent) chunk = count - sent;
      repeat (chunk) begin
        if ($urandom_range(9) == 0) begin
          w.page_number = PAGE_BITS'($urandom());
        end else begin
          w.page_number = pool[$urandom_range(ws - 1)];
        end
        w.last_reference = ($urandom_range(39) == 0);
        send_word(w);
        sent++;
      end
    end
    drain_results();
  endtask

  // Result channel held off for a long stretch while references keep coming:
  // the pending result blocks the next update and in_stall backs up.
  task automatic test_result_backlog();
    snd_pct = 0;
    rcv_pct = 0;
    drain_results();
    write_frames(cfg_word_t'(4));
    hold_req = 300;
    repeat (40) send_word(ref_word(PAGE_BITS'($urandom_range(9)), 1'b0));
    drain_results();
  endtask

  initial begin
    clear_tables();
    tbl_frames = FRAMES_IN_USE_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_reference_stream(19, 49, 395);
    test_reference_stream(49, 19, 395);
    test_reference_stream(0, 0, 395);
    test_result_backlog();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d result words never arrived", expected_results.size());
      n_bad += expected_results.size();
    end

    $display("Run: %0d references, %0d result words, %0d frame-count writes.",
             n_refs, n_results, n_cfg);
    $display("Directed corners, three idle/stall mixes and a long result hold-off.");
    if (n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### lru_page_replacement.f
design/lru_pkg.sv
design/lru_ram.sv
design/lru_scan.sv
design/lru_page_replacement.sv
test/lru_page_replacement_tb.sv
